/* rtl/dfc_pkg.sv */
package dfc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FINAL,
    OP_REGOP,
    OP_ADDR
  } cmd_op_e;

  typedef enum logic [1:0] {
    OPW_8,
    OPW_16,
    OPW_32
  } opw_e;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic ST_DIV_ZERO = 1'b0;
  localparam logic ST_OVERFLOW = 1'b1;

  localparam logic [7:0] BYTE_LOCK   = 8'hF0;
  localparam logic [7:0] BYTE_REPNE  = 8'hF2;
  localparam logic [7:0] BYTE_REP    = 8'hF3;
  localparam logic [7:0] BYTE_SEG_CS = 8'h2E;
  localparam logic [7:0] BYTE_SEG_SS = 8'h36;
  localparam logic [7:0] BYTE_SEG_DS = 8'h3E;
  localparam logic [7:0] BYTE_SEG_ES = 8'h26;
  localparam logic [7:0] BYTE_SEG_FS = 8'h64;
  localparam logic [7:0] BYTE_SEG_GS = 8'h65;
  localparam logic [7:0] BYTE_OPSIZE = 8'h66;
  localparam logic [7:0] BYTE_DIV8   = 8'hF6;
  localparam logic [7:0] BYTE_DIV    = 8'hF7;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_NOBASE  = 3'd5;
  localparam logic [2:0] IDX_NONE   = 3'd4;
  localparam logic [2:0] REG_ESP    = 3'd4;

  localparam logic [7:0] STACK_ADJUST_RST = 8'd72;

  typedef struct packed {
    cmd_op_e     op;
    logic [2:0]  reg_a;
    logic [2:0]  reg_b;
    logic        use_a;
    logic        use_b;
    logic        hi_byte;
    logic [1:0]  scale;
    opw_e        width;
    logic        status;
    logic [31:0] data;
  } dfc_cmd_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } dfc_res_t;

  function automatic logic nz_masked(logic [31:0] v, opw_e w);
    logic r;
    unique case (w)
      OPW_8:   r = v[7:0] != 8'd0;
      OPW_16:  r = v[15:0] != 16'd0;
      default: r = v != 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/x86_divide_fault_classifier.sv */
// Classifies a faulting DIV/IDIV as divide by zero or overflow. Send register loads
// (tuser req_type 0), then instruction bytes (1); when the operand is in memory at a
// nonzero address the block emits a read request (result_kind 0) and waits for the
// reply (2), then emits the final class (result_kind 1). Items are taken one per
// cycle while the queue has room. The byte that completes an effective address drops
// s_axis_tready until the back end (register read, then address adder) knows whether
// the address is zero, longer if earlier items are still queued or the output is
// stalled. A result passes through the queue, the register-read stage and the output
// register. The stack register adjustment is written on the cfg port.
module x86_divide_fault_classifier
  import dfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // stack_adjust
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // reg_index[2:0], data_value[34:3], zero pad
  input  logic [2:0]  s_axis_tuser,   // req_type[1:0], access_fault[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_address[31:0], read_size[33:32],
                                      // fault_status[34], zero pad
  output logic [0:0]  m_axis_tuser    // result_kind
);

  logic        push, full, pop, empty;
  dfc_cmd_t    push_cmd, head;
  dfc_res_t    res;
  logic        kind, status;
  logic [31:0] addr;
  logic [1:0]  size;

  assign cfg_ready_o = 1'b1;

  dfc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_type_i     (s_axis_tuser[1:0]),
    .reg_index_i    (s_axis_tdata[2:0]),
    .data_value_i   (s_axis_tdata[34:3]),
    .access_fault_i (s_axis_tuser[2]),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full),
    .res_i          (res)
  );

  dfc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  dfc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .res_o          (res),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_kind_o  (kind),
    .read_address_o (addr),
    .read_size_o    (size),
    .fault_status_o (status)
  );

  assign m_axis_tdata = {5'd0, status, size, addr};
  assign m_axis_tuser = kind;

endmodule

/* rtl/dfc_front.sv */
module dfc_front
  import dfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  reg_index_i,
  input  logic [31:0] data_value_i,
  input  logic        access_fault_i,
  output logic        push_o,
  output dfc_cmd_t    cmd_o,
  input  logic        full_i,
  input  dfc_res_t    res_i
);

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_MODRM  = 3'd1;
  localparam logic [2:0] PH_SIB    = 3'd2;
  localparam logic [2:0] PH_DISP   = 3'd3;
  localparam logic [2:0] PH_WAIT   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  opw_e        width_q, width_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [7:0]  sib_q, sib_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  left_q, left_d;
  logic        blocked_q, blocked_d;
  logic        accept;
  logic [7:0]  b;
  logic [31:0] acc_n;
  logic [2:0]  left_n;
  logic [1:0]  mod_q;

  function automatic dfc_cmd_t addr_cmd(logic [7:0] m, logic [7:0] s, logic [31:0] d, opw_e w);
    dfc_cmd_t c;
    c       = '0;
    c.op    = OP_ADDR;
    c.width = w;
    c.data  = d;
    if (m[2:0] == RM_SIB) begin
      c.reg_a = s[2:0];
      c.use_a = !(s[2:0] == RM_NOBASE && m[7:6] == MOD_NODISP);
      c.reg_b = s[5:3];
      c.use_b = s[5:3] != IDX_NONE;
      c.scale = s[7:6];
    end else if (m[7:6] == MOD_NODISP && m[2:0] == RM_NOBASE) begin
      c.use_a = 1'b0;
    end else begin
      c.reg_a = m[2:0];
      c.use_a = 1'b1;
    end
    return c;
  endfunction

  assign in_ready_o = !blocked_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = data_value_i[7:0];
  assign acc_n      = {b, acc_q[31:8]};
  assign left_n     = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
  assign mod_q      = modrm_q[7:6];

  always_comb begin
    phase_d   = phase_q;
    width_d   = width_q;
    modrm_d   = modrm_q;
    sib_d     = sib_q;
    acc_d     = acc_q;
    left_d    = left_q;
    blocked_d = blocked_q;
    push_o    = 1'b0;
    cmd_o     = '0;

    if (res_i.valid) begin
      blocked_d = 1'b0;
      if (res_i.zero) begin
        phase_d = PH_PREFIX;
        width_d = OPW_32;
      end
    end

    if (accept) begin
      unique case (req_type_i)
        REQ_LOAD: begin
          push_o      = 1'b1;
          cmd_o.op    = OP_LOAD;
          cmd_o.reg_a = reg_index_i;
          cmd_o.data  = data_value_i;
        end
        REQ_BYTE: begin
          if (phase_q != PH_WAIT) begin
            cmd_o.op     = OP_FINAL;
            cmd_o.status = ST_DIV_ZERO;
            if (access_fault_i) begin
              push_o  = 1'b1;
              phase_d = PH_PREFIX;
              width_d = OPW_32;
            end else begin
              unique case (phase_q)
                PH_PREFIX: begin
                  unique case (b)
                    BYTE_LOCK, BYTE_REPNE, BYTE_REP, BYTE_SEG_CS, BYTE_SEG_SS,
                    BYTE_SEG_DS, BYTE_SEG_ES, BYTE_SEG_FS, BYTE_SEG_GS: begin
                    end
                    BYTE_OPSIZE: width_d = OPW_16;
                    BYTE_DIV8: begin
                      width_d = OPW_8;
                      phase_d = PH_MODRM;
                    end
                    BYTE_DIV: phase_d = PH_MODRM;
                    default: begin
                      push_o  = 1'b1;
                      width_d = OPW_32;
                    end
                  endcase
                end
                PH_MODRM: begin
                  modrm_d = b;
                  if (b[7:6] == MOD_REG) begin
                    push_o        = 1'b1;
                    cmd_o.op      = OP_REGOP;
                    cmd_o.width   = width_q;
                    cmd_o.hi_byte = (width_q == OPW_8) && b[2];
                    cmd_o.reg_a   = (width_q == OPW_8) ? {1'b0, b[1:0]} : b[2:0];
                    phase_d       = PH_PREFIX;
                    width_d       = OPW_32;
                  end else if (b[2:0] == RM_SIB) begin
                    phase_d = PH_SIB;
                  end else if (b[7:6] == MOD_DISP8) begin
                    acc_d   = '0;
                    left_d  = 3'd1;
                    phase_d = PH_DISP;
                  end else if (b[7:6] == MOD_DISP32 || b[2:0] == RM_NOBASE) begin
                    acc_d   = '0;
                    left_d  = 3'd4;
                    phase_d = PH_DISP;
                  end else begin
                    push_o    = 1'b1;
                    cmd_o     = addr_cmd(b, sib_q, 32'd0, width_q);
                    phase_d   = PH_WAIT;
                    blocked_d = 1'b1;
                  end
                end
                PH_SIB: begin
                  sib_d = b;
                  if (mod_q == MOD_DISP8) begin
                    acc_d   = '0;
                    left_d  = 3'd1;
                    phase_d = PH_DISP;
                  end else if (mod_q == MOD_DISP32 || b[2:0] == RM_NOBASE) begin
                    acc_d   = '0;
                    left_d  = 3'd4;
                    phase_d = PH_DISP;
                  end else begin
                    push_o    = 1'b1;
                    cmd_o     = addr_cmd(modrm_q, b, 32'd0, width_q);
                    phase_d   = PH_WAIT;
                    blocked_d = 1'b1;
                  end
                end
                PH_DISP: begin
                  acc_d  = acc_n;
                  left_d = left_n;
                  if (left_n == 3'd0) begin
                    push_o    = 1'b1;
                    cmd_o     = addr_cmd(modrm_q, sib_q,
                                         (mod_q == MOD_DISP8) ?
                                         {{24{acc_n[31]}}, acc_n[31:24]} : acc_n,
                                         width_q);
                    phase_d   = PH_WAIT;
                    blocked_d = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        REQ_REPLY: begin
          if (phase_q == PH_WAIT) begin
            push_o       = 1'b1;
            cmd_o.op     = OP_FINAL;
            cmd_o.status = access_fault_i ? ST_DIV_ZERO : nz_masked(data_value_i, width_q);
            phase_d      = PH_PREFIX;
            width_d      = OPW_32;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX;
      width_q   <= OPW_32;
      modrm_q   <= '0;
      sib_q     <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      blocked_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      width_q   <= width_d;
      modrm_q   <= modrm_d;
      sib_q     <= sib_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      blocked_q <= blocked_d;
    end
  end

endmodule

/* rtl/dfc_fifo.sv */
module dfc_fifo
  import dfc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dfc_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output dfc_cmd_t head_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dfc_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/dfc_back.sv */
module dfc_back
  import dfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        empty_i,
  input  dfc_cmd_t    head_i,
  output logic        pop_o,
  output dfc_res_t    res_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] read_address_o,
  output logic [1:0]  read_size_o,
  output logic        fault_status_o
);

  logic [31:0] rf_q [8];
  logic [7:0]  vld_q;
  logic [7:0]  stack_adj_q;
  logic        b_valid_q;
  dfc_cmd_t    b_cmd_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic        va_q, vb_q;
  logic        out_valid_q;
  logic        kind_q, status_q;
  logic [31:0] addr_q;
  logic [1:0]  size_q;
  logic        b_go, out_free, is_load;
  logic [31:0] wdata, rd_a, rd_b, v8, ea;
  logic        kind_d, status_d;
  logic [31:0] addr_d;
  logic [1:0]  size_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign b_go     = b_valid_q && out_free;
  assign pop_o    = !empty_i && (!b_valid_q || b_go);
  assign is_load  = head_i.op == OP_LOAD;
  assign wdata    = (head_i.reg_a == REG_ESP) ? head_i.data + {24'd0, stack_adj_q}
                                              : head_i.data;

  always_ff @(posedge clk_i) begin
    if (pop_o && is_load) begin
      rf_q[head_i.reg_a] <= wdata;
    end
    if (pop_o) begin
      rd_a_q <= rf_q[head_i.reg_a];
      rd_b_q <= rf_q[head_i.reg_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_cmd_q <= head_i;
      va_q    <= vld_q[head_i.reg_a];
      vb_q    <= vld_q[head_i.reg_b];
    end
    if (b_go) begin
      kind_q   <= kind_d;
      addr_q   <= addr_d;
      size_q   <= size_d;
      status_q <= status_d;
    end
  end

  assign rd_a = va_q ? rd_a_q : 32'd0;
  assign rd_b = vb_q ? rd_b_q : 32'd0;
  assign v8   = b_cmd_q.hi_byte ? {24'd0, rd_a[15:8]} : rd_a;
  assign ea   = (b_cmd_q.use_a ? rd_a : 32'd0)
              + (b_cmd_q.use_b ? (rd_b << b_cmd_q.scale) : 32'd0)
              + b_cmd_q.data;

  always_comb begin
    kind_d   = KIND_FINAL;
    addr_d   = '0;
    size_d   = '0;
    status_d = ST_DIV_ZERO;
    unique case (b_cmd_q.op)
      OP_FINAL: status_d = b_cmd_q.status;
      OP_REGOP: status_d = nz_masked(v8, b_cmd_q.width);
      OP_ADDR: begin
        if (ea != 32'd0) begin
          kind_d = KIND_READ;
          addr_d = ea;
          size_d = b_cmd_q.width;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid = b_go && b_cmd_q.op == OP_ADDR;
  assign res_o.zero  = ea == 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      stack_adj_q <= STACK_ADJUST_RST;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        stack_adj_q <= cfg_data_i;
      end
      if (pop_o && is_load) begin
        vld_q[head_i.reg_a] <= 1'b1;
      end
      if (pop_o) begin
        b_valid_q <= !is_load;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
      if (b_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign read_address_o = addr_q;
  assign read_size_o    = size_q;
  assign fault_status_o = status_q;

endmodule

/* rtl/dfc_checker.sv */
module dfc_checker
  import dfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_final_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_FINAL |-> m_axis_tdata[33:0] == 34'd0)
    else $error("final item carries address or size");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_READ |->
      m_axis_tdata[31:0] != 32'd0 && m_axis_tdata[34] == ST_DIV_ZERO
      && m_axis_tdata[33:32] != 2'd3)
    else $error("malformed read request");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("nonzero pad in result item");

endmodule

bind x86_divide_fault_classifier dfc_checker u_dfc_checker (.*);
